FILE: hdl/dbem_pkg.sv
// Shared types and constants for the DMA buffer event monitor.
// Used by dbem_cell and by the top level dma_buffer_event_monitor; no dependencies.

package dbem_pkg;

  // Fixed field widths.
  localparam int CmdW   = 2;
  localparam int FrameW = 32;
  localparam int StampW = 48;
  localparam int SizeW  = 24;
  localparam int CountW = 32;
  localparam int ByteW  = 48;

  // Event codes on the cmd field.
  typedef enum logic [CmdW-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Search token that travels down the row of table cells.
  typedef struct packed {
    logic              valid;
    logic              match;
    logic              empty;
    logic [FrameW-1:0] frame;
    logic [StampW-1:0] stamp;
    logic [SizeW-1:0]  size;
  } scan_tok_t;

  // Table write control broadcast to all cells.
  typedef struct packed {
    logic              clear;
    logic              en;
    logic [FrameW-1:0] frame;
    logic [StampW-1:0] stamp;
    logic [SizeW-1:0]  size;
  } entry_wr_t;

endpackage

FILE: hdl/dbem_cell.sv
// One table entry of the DMA buffer event monitor plus one stage of the search chain.
// Depends on dbem_pkg for the token and write-control types.

module dbem_cell
  import dbem_pkg::*;
#(
  parameter int AddrW = 32,
  parameter int IdxW  = 3,
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  scan_tok_t       tok_in,
  input  logic [AddrW-1:0] tok_addr_in,
  input  logic [IdxW-1:0] match_idx_in,
  input  logic [IdxW-1:0] empty_idx_in,
  output scan_tok_t       tok_out,
  output logic [AddrW-1:0] tok_addr_out,
  output logic [IdxW-1:0] match_idx_out,
  output logic [IdxW-1:0] empty_idx_out,
  input  entry_wr_t       wr,
  input  logic [IdxW-1:0] wr_idx,
  input  logic [AddrW-1:0] wr_addr
);

  logic [AddrW-1:0]  entry_addr;
  logic [FrameW-1:0] entry_frame;
  logic [StampW-1:0] entry_stamp;
  logic [SizeW-1:0]  entry_size;

  scan_tok_t       tok_next;
  logic [IdxW-1:0] match_idx_next;
  logic [IdxW-1:0] empty_idx_next;
  logic            wr_sel;

  assign wr_sel = wr.en && (wr_idx == IdxW'(INDEX));

  // Entry address: zero marks an empty entry, so reset and release clear it.
  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      entry_addr <= '0;
    end else if (wr_sel) begin
      entry_addr <= wr_addr;
    end
  end

  // Record fields are only read through a valid entry, so they need no reset.
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      entry_frame <= wr.frame;
      entry_stamp <= wr.stamp;
      entry_size  <= wr.size;
    end
  end

  // The first matching entry and the first empty entry along the row win.
  always_comb begin
    tok_next       = tok_in;
    match_idx_next = match_idx_in;
    empty_idx_next = empty_idx_in;
    if (!tok_in.match && (entry_addr == tok_addr_in)) begin
      tok_next.match = 1'b1;
      tok_next.frame = entry_frame;
      tok_next.stamp = entry_stamp;
      tok_next.size  = entry_size;
      match_idx_next = IdxW'(INDEX);
    end
    if (!tok_in.empty && (entry_addr == '0)) begin
      tok_next.empty = 1'b1;
      empty_idx_next = IdxW'(INDEX);
    end
  end

  // Hand the token to the next cell; only its valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.match <= tok_next.match;
    tok_out.empty <= tok_next.empty;
    tok_out.frame <= tok_next.frame;
    tok_out.stamp <= tok_next.stamp;
    tok_out.size  <= tok_next.size;
    tok_addr_out  <= tok_addr_in;
    match_idx_out <= match_idx_next;
    empty_idx_out <= empty_idx_next;
  end

endmodule

FILE: hdl/dma_buffer_event_monitor.sv
// Top level of the DMA buffer event monitor: sequencer, counters and result register.
// Depends on dbem_pkg and on a row of dbem_cell instances holding the buffer table.
//
// Usage: one event request enters on in_valid/in_stall with cmd, buffer_addr,
// buffer_length, received_bytes and now_time. Each request gives exactly one
// result request on out_valid/out_stall carrying the lookup record and all counters.
// The user writes expected_frame_bytes through cfg_wr_en/cfg_wr_data only while idle;
// the block does not enforce this. Request and release events, and finish or lookup
// events with address zero, go from the idle state straight to the commit state.
// Finish and lookup events with a nonzero address send a search token down the row of
// TABLE_ENTRIES cells, one cell per cycle, and reach the commit state once it leaves
// the last cell. A commit loads the result into the output register, and a new event
// is accepted only once the sequencer is back in idle. in_stall is high while an
// event is in progress. A result that waits on out_stall stays in the output register;
// the next event may be accepted meanwhile, but it is committed only once that result
// is taken. Synchronous reset clears the counters, the destination, the result valid
// flag and every table entry.

module dma_buffer_event_monitor
  import dbem_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8,
  parameter int ADDRESS_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [SizeW-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CmdW-1:0]      cmd,
  input  logic [31:0]          buffer_addr,
  input  logic [SizeW-1:0]     buffer_length,
  input  logic [SizeW-1:0]     received_bytes,
  input  logic [StampW-1:0]    now_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 found,
  output logic [FrameW-1:0]    frame_number,
  output logic [StampW-1:0]    frame_time,
  output logic [SizeW-1:0]     frame_size,
  output logic [CountW-1:0]    request_total,
  output logic [CountW-1:0]    missing_total,
  output logic [CountW-1:0]    finished_total,
  output logic [ByteW-1:0]     byte_sum,
  output logic [CountW-1:0]    reused_total,
  output logic [CountW-1:0]    untracked_total
);

  localparam int AddrW = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
  localparam int IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Sequencer.
  state_t state, state_next;
  logic   in_accept;
  logic   need_scan;
  logic   slot_free;
  logic   capture;
  logic   commit_en;

  // Captured event.
  cmd_t              cmd_q;
  logic [AddrW-1:0]  addr_q;
  logic [SizeW-1:0]  blen_q;
  logic [SizeW-1:0]  rbytes_q;
  logic [StampW-1:0] now_q;
  logic [AddrW-1:0]  addr_in;

  // Search result.
  logic              sc_match;
  logic              sc_empty;
  logic [IdxW-1:0]   sc_match_idx;
  logic [IdxW-1:0]   sc_empty_idx;
  logic [FrameW-1:0] sc_frame;
  logic [StampW-1:0] sc_stamp;
  logic [SizeW-1:0]  sc_size;

  // State counters and register.
  logic [SizeW-1:0]  expected_frame_bytes;
  logic [CountW-1:0] request_count, request_count_next;
  logic [CountW-1:0] missing_count, missing_count_next;
  logic [CountW-1:0] finished_count, finished_count_next;
  logic [ByteW-1:0]  byte_total, byte_total_next;
  logic [CountW-1:0] reused_count, reused_count_next;
  logic [CountW-1:0] untracked_count, untracked_count_next;
  logic [AddrW-1:0]  next_target, next_target_next;

  // Table write port and cell chain.
  entry_wr_t         wr;
  logic [IdxW-1:0]   wr_idx;
  logic              hit;
  scan_tok_t         tok     [TABLE_ENTRIES+1];
  logic [AddrW-1:0]  tok_addr[TABLE_ENTRIES+1];
  logic [IdxW-1:0]   m_idx   [TABLE_ENTRIES+1];
  logic [IdxW-1:0]   e_idx   [TABLE_ENTRIES+1];

  assign addr_in   = buffer_addr[AddrW-1:0];
  assign in_accept = in_valid && !in_stall;
  assign need_scan = ((cmd_t'(cmd) == CMD_FINISH) || (cmd_t'(cmd) == CMD_LOOKUP)) &&
                     (addr_in != '0);
  assign slot_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = need_scan ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (tok[TABLE_ENTRIES].valid) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    capture   = 1'b0;
    commit_en = 1'b0;
    case (state)
      ST_IDLE:   in_stall  = 1'b0;
      ST_SCAN:   capture   = tok[TABLE_ENTRIES].valid;
      ST_COMMIT: commit_en = slot_free;
      default:   in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_frame_bytes <= '0;
    end else if (cfg_wr_en) begin
      expected_frame_bytes <= cfg_wr_data;
    end
  end

  // Event capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q    <= cmd_t'(cmd);
      addr_q   <= addr_in;
      blen_q   <= buffer_length;
      rbytes_q <= received_bytes;
      now_q    <= now_time;
    end
  end

  // Search result capture; events that skip the search see neither a match nor a slot.
  always_ff @(posedge clk) begin
    if (rst || in_accept) begin
      sc_match <= 1'b0;
      sc_empty <= 1'b0;
    end else if (capture) begin
      sc_match <= tok[TABLE_ENTRIES].match;
      sc_empty <= tok[TABLE_ENTRIES].empty;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      sc_match_idx <= m_idx[TABLE_ENTRIES];
      sc_empty_idx <= e_idx[TABLE_ENTRIES];
      sc_frame     <= tok[TABLE_ENTRIES].frame;
      sc_stamp     <= tok[TABLE_ENTRIES].stamp;
      sc_size      <= tok[TABLE_ENTRIES].size;
    end
  end

  // Search token enters the first cell at the accepting edge.
  always_comb begin
    tok[0].valid = in_accept && need_scan;
    tok[0].match = 1'b0;
    tok[0].empty = 1'b0;
    tok[0].frame = '0;
    tok[0].stamp = '0;
    tok[0].size  = '0;
    tok_addr[0]  = addr_in;
    m_idx[0]     = '0;
    e_idx[0]     = '0;
  end

  // Row of table cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    dbem_cell #(
      .AddrW (AddrW),
      .IdxW  (IdxW),
      .INDEX (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .tok_in        (tok[i]),
      .tok_addr_in   (tok_addr[i]),
      .match_idx_in  (m_idx[i]),
      .empty_idx_in  (e_idx[i]),
      .tok_out       (tok[i+1]),
      .tok_addr_out  (tok_addr[i+1]),
      .match_idx_out (m_idx[i+1]),
      .empty_idx_out (e_idx[i+1]),
      .wr            (wr),
      .wr_idx        (wr_idx),
      .wr_addr       (addr_q)
    );
  end

  // Counter updates and table write for the committing event.
  assign hit    = sc_match || sc_empty;
  assign wr_idx = sc_match ? sc_match_idx : sc_empty_idx;

  always_comb begin
    request_count_next   = request_count;
    missing_count_next   = missing_count;
    finished_count_next  = finished_count;
    byte_total_next      = byte_total;
    reused_count_next    = reused_count;
    untracked_count_next = untracked_count;
    next_target_next     = next_target;
    wr.clear             = 1'b0;
    wr.en                = 1'b0;
    wr.frame             = finished_count + 1'b1;
    wr.stamp             = now_q;
    wr.size              = rbytes_q;
    if (commit_en) begin
      case (cmd_q)
        CMD_REQUEST: begin
          request_count_next = request_count + 1'b1;
          next_target_next   = addr_q;
          if ((addr_q == '0) || (expected_frame_bytes == '0) ||
              (blen_q < expected_frame_bytes)) begin
            missing_count_next = missing_count + 1'b1;
          end
        end
        CMD_FINISH: begin
          finished_count_next = finished_count + 1'b1;
          byte_total_next     = byte_total + ByteW'(rbytes_q);
          if ((addr_q != '0) && (addr_q == next_target)) begin
            reused_count_next = reused_count + 1'b1;
          end
          if (hit) begin
            wr.en = 1'b1;
          end else begin
            untracked_count_next = untracked_count + 1'b1;
          end
        end
        CMD_RELEASE: begin
          wr.clear         = 1'b1;
          next_target_next = '0;
        end
        default: begin
          // A lookup changes no state.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_count   <= '0;
      missing_count   <= '0;
      finished_count  <= '0;
      byte_total      <= '0;
      reused_count    <= '0;
      untracked_count <= '0;
      next_target     <= '0;
    end else begin
      request_count   <= request_count_next;
      missing_count   <= missing_count_next;
      finished_count  <= finished_count_next;
      byte_total      <= byte_total_next;
      reused_count    <= reused_count_next;
      untracked_count <= untracked_count_next;
      next_target     <= next_target_next;
    end
  end

  // Result register. The counters change only at a commit, which waits for a free
  // slot, so they feed the result ports directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_en) begin
      if ((cmd_q == CMD_LOOKUP) && sc_match) begin
        found        <= 1'b1;
        frame_number <= sc_frame;
        frame_time   <= sc_stamp;
        frame_size   <= sc_size;
      end else begin
        found        <= 1'b0;
        frame_number <= '0;
        frame_time   <= '0;
        frame_size   <= '0;
      end
    end
  end

  assign request_total   = request_count;
  assign missing_total   = missing_count;
  assign finished_total  = finished_count;
  assign byte_sum        = byte_total;
  assign reused_total    = reused_count;
  assign untracked_total = untracked_count;

  // The search token leaves the row only while the sequencer waits for it.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[TABLE_ENTRIES].valid |-> (state == ST_SCAN))
    else $error("search token left the cell row outside the scan state");

  // A table write needs a matching or empty entry from the search.
  a_write_has_slot: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (sc_match || sc_empty))
    else $error("table write without a matching or empty entry");

  // The finish counter moves only on the edge that commits an event.
  a_count_at_commit: assert property (@(posedge clk) disable iff (rst)
    !$stable(finished_count) |-> $past(commit_en))
    else $error("finish counter changed outside a commit");

  // A result is loaded only when the previous one has left or is leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    commit_en |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

endmodule

FILE: bench/tb_dma_buffer_event_monitor.sv
// Self-checking testbench for dma_buffer_event_monitor: directed event table, then random phases.
// Depends on dbem_pkg and the dma_buffer_event_monitor RTL; expectations come from a local predictor or a pinned row.
`timescale 1ns / 100ps

module tb_dma_buffer_event_monitor;
  import dbem_pkg::*;

  localparam int TableEntries  = 8;
  localparam int PoolSize      = 12;
  localparam int ItemsPerPhase = 250;
  localparam int PhaseCount    = 5;
  localparam int IdleLimit     = 4000;
  localparam int MaxReports    = 100;

  // One event request as the sender presents it.
  typedef struct packed {
    cmd_t              cmd;
    logic [31:0]       addr;
    logic [SizeW-1:0]  length;
    logic [SizeW-1:0]  received;
    logic [StampW-1:0] stamp;
  } mon_event_t;

  // One result request with the lookup record and every counter.
  typedef struct packed {
    logic              found;
    logic [FrameW-1:0] frame_number;
    logic [StampW-1:0] frame_time;
    logic [SizeW-1:0]  frame_size;
    logic [CountW-1:0] request_total;
    logic [CountW-1:0] missing_total;
    logic [CountW-1:0] finished_total;
    logic [ByteW-1:0]  byte_sum;
    logic [CountW-1:0] reused_total;
    logic [CountW-1:0] untracked_total;
  } mon_result_t;

  // A directed row; where pinned is set, the typed-in result is the expectation.
  typedef struct packed {
    mon_event_t  ev;
    logic        pinned;
    mon_result_t want;
  } script_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [SizeW-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [CmdW-1:0]   cmd;
  logic [31:0]       buffer_addr;
  logic [SizeW-1:0]  buffer_length;
  logic [SizeW-1:0]  received_bytes;
  logic [StampW-1:0] now_time;
  logic              out_valid;
  logic              out_stall;
  logic              found;
  logic [FrameW-1:0] frame_number;
  logic [StampW-1:0] frame_time;
  logic [SizeW-1:0]  frame_size;
  logic [CountW-1:0] request_total;
  logic [CountW-1:0] missing_total;
  logic [CountW-1:0] finished_total;
  logic [ByteW-1:0]  byte_sum;
  logic [CountW-1:0] reused_total;
  logic [CountW-1:0] untracked_total;

  dma_buffer_event_monitor #(
    .TABLE_ENTRIES(TableEntries),
    .ADDRESS_BITS (32)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .buffer_addr    (buffer_addr),
    .buffer_length  (buffer_length),
    .received_bytes (received_bytes),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .frame_number   (frame_number),
    .frame_time     (frame_time),
    .frame_size     (frame_size),
    .request_total  (request_total),
    .missing_total  (missing_total),
    .finished_total (finished_total),
    .byte_sum       (byte_sum),
    .reused_total   (reused_total),
    .untracked_total(untracked_total)
  );

  // Predictor state: the monitor's counters, destination and buffer table.
  logic [SizeW-1:0]  frame_goal;
  logic [CountW-1:0] requests_seen;
  logic [CountW-1:0] short_requests;
  logic [CountW-1:0] frames_done;
  logic [ByteW-1:0]  bytes_received;
  logic [CountW-1:0] reuses;
  logic [CountW-1:0] untracked;
  logic [31:0]       destination;
  logic [31:0]       slot_addr  [TableEntries];
  logic [FrameW-1:0] slot_frame [TableEntries];
  logic [StampW-1:0] slot_stamp [TableEntries];
  logic [SizeW-1:0]  slot_size  [TableEntries];

  mon_result_t pending_results [$];
  logic [31:0] addr_pool [PoolSize];
  logic        calm;
  int          mismatches;
  int          idle_cycles;

  // Directed events, written with the frame goal at 1000 bytes.
  script_row_t directed_rows [25] = '{
    '{'{CMD_LOOKUP,  32'h0000_0000, 24'd0,      24'd0,      48'd0}, 1'b1, '0},
    '{'{CMD_LOOKUP,  32'hFFFF_FFFF, 24'd0,      24'd0,      48'd0}, 1'b1, '0},
    '{'{CMD_REQUEST, 32'h0000_0000, 24'hFFFFFF, 24'd0,      48'd0}, 1'b1,
      '{1'b0, 32'd0, 48'd0, 24'd0, 32'd1, 32'd1, 32'd0, 48'd0, 32'd0, 32'd0}},
    '{'{CMD_REQUEST, 32'hFFFF_FFFF, 24'hFFFFFF, 24'd0,      48'd0}, 1'b1,
      '{1'b0, 32'd0, 48'd0, 24'd0, 32'd2, 32'd1, 32'd0, 48'd0, 32'd0, 32'd0}},
    '{'{CMD_REQUEST, 32'h0000_1000, 24'd999,    24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_REQUEST, 32'h0000_1000, 24'd1000,   24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_1000, 24'd0,      24'hFFFFFF, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{CMD_LOOKUP,  32'h0000_1000, 24'd0,      24'd0,      48'd0}, 1'b1,
      '{1'b1, 32'd1, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF,
        32'd4, 32'd2, 32'd1, 48'h00_0000_FF_FFFF, 32'd1, 32'd0}},
    '{'{CMD_FINISH,  32'h0000_0000, 24'd0,      24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_LOOKUP,  32'h0000_0000, 24'd0,      24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_2000, 24'd0,      24'h000100, 48'd1000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_3000, 24'd0,      24'h000200, 48'd2000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_4000, 24'd0,      24'h000300, 48'd3000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_5000, 24'd0,      24'h000400, 48'd4000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_6000, 24'd0,      24'h000500, 48'd5000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_7000, 24'd0,      24'h000600, 48'd6000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h8000_0000, 24'd0,      24'h000700, 48'd7000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_9000, 24'd0,      24'h000800, 48'd8000}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_1000, 24'd0,      24'h123456, 48'h1234_5678_9ABC}, 1'b0, '0},
    '{'{CMD_LOOKUP,  32'h0000_1000, 24'd0,      24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_LOOKUP,  32'h0000_9000, 24'd0,      24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_RELEASE, 32'h0000_1000, 24'd0,      24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_LOOKUP,  32'h0000_1000, 24'd0,      24'd0,      48'd0}, 1'b0, '0},
    '{'{CMD_FINISH,  32'h0000_1000, 24'd0,      24'd77,     48'd9000}, 1'b0, '0},
    '{'{CMD_REQUEST, 32'h0000_1000, 24'd0,      24'd0,      48'd0}, 1'b0, '0}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one accepted event and advances the predictor state.
  function automatic mon_result_t predict_event(input mon_event_t ev);
    mon_result_t res;
    int slot;
    res = '0;
    slot = -1;
    case (ev.cmd)
      CMD_REQUEST: begin
        requests_seen++;
        destination = ev.addr;
        if (ev.addr == '0 || frame_goal == '0 || ev.length < frame_goal) short_requests++;
      end
      CMD_FINISH: begin
        frames_done++;
        bytes_received = bytes_received + ByteW'(ev.received);
        if (ev.addr != '0 && ev.addr == destination) reuses++;
        // A matching entry wins over the first empty one.
        if (ev.addr != '0) begin
          for (int i = 0; i < TableEntries; i++)
            if (slot < 0 && slot_addr[i] == ev.addr) slot = i;
          for (int i = 0; i < TableEntries; i++)
            if (slot < 0 && slot_addr[i] == '0) slot = i;
        end
        if (slot >= 0) begin
          slot_addr[slot]  = ev.addr;
          slot_frame[slot] = frames_done;
          slot_stamp[slot] = ev.stamp;
          slot_size[slot]  = ev.received;
        end else begin
          untracked++;
        end
      end
      CMD_LOOKUP: begin
        if (ev.addr != '0) begin
          for (int i = 0; i < TableEntries; i++) begin
            if (!res.found && slot_addr[i] == ev.addr) begin
              res.found        = 1'b1;
              res.frame_number = slot_frame[i];
              res.frame_time   = slot_stamp[i];
              res.frame_size   = slot_size[i];
            end
          end
        end
      end
      default: begin
        // Release empties the table and forgets the destination.
        for (int i = 0; i < TableEntries; i++) slot_addr[i] = '0;
        destination = '0;
      end
    endcase
    res.request_total   = requests_seen;
    res.missing_total   = short_requests;
    res.finished_total  = frames_done;
    res.byte_sum        = bytes_received;
    res.reused_total    = reuses;
    res.untracked_total = untracked;
    return res;
  endfunction

  // Mostly table addresses, with zero and arbitrary addresses mixed in.
  function automatic logic [31:0] pick_address();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 25) return $urandom;
    return addr_pool[$urandom_range(PoolSize - 1)];
  endfunction

  // Builds an event with random lengths, clustered around the frame goal.
  function automatic mon_event_t make_event(input cmd_t kind, input logic [31:0] addr);
    mon_event_t ev;
    ev.cmd  = kind;
    ev.addr = addr;
    case ($urandom_range(5))
      0:       ev.length = frame_goal - 1'b1;
      1:       ev.length = frame_goal;
      2:       ev.length = frame_goal + 1'b1;
      3:       ev.length = '0;
      4:       ev.length = '1;
      default: ev.length = SizeW'($urandom);
    endcase
    case ($urandom_range(9))
      0:       ev.received = '0;
      1:       ev.received = '1;
      default: ev.received = SizeW'($urandom);
    endcase
    ev.stamp = {16'($urandom), 32'($urandom)};
    return ev;
  endfunction

  // Presents one event request, waits until it is taken, then records its expectation.
  task automatic send_event(input mon_event_t ev, input logic pinned, input mon_result_t want);
    mon_result_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    cmd            <= ev.cmd;
    buffer_addr    <= ev.addr;
    buffer_length  <= ev.length;
    received_bytes <= ev.received;
    now_time       <= ev.stamp;
    do @(posedge clk); while (in_stall);
    predicted = predict_event(ev);
    pending_results.push_back(pinned ? want : predicted);
  endtask

  // Lets the block drain completely, then writes the frame goal.
  task automatic write_frame_goal(input logic [SizeW-1:0] goal);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TableEntries + 2) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= goal;
    @(posedge clk);
    frame_goal = goal;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  // Result side stalls at random, except during the calm phase.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    mon_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result, expected none, actual request_total %0h",
                   $time, request_total);
      end else begin
        want = pending_results.pop_front();
        check_field("found",           64'(want.found),           64'(found));
        check_field("frame_number",    64'(want.frame_number),    64'(frame_number));
        check_field("frame_time",      64'(want.frame_time),      64'(frame_time));
        check_field("frame_size",      64'(want.frame_size),      64'(frame_size));
        check_field("request_total",   64'(want.request_total),   64'(request_total));
        check_field("missing_total",   64'(want.missing_total),   64'(missing_total));
        check_field("finished_total",  64'(want.finished_total),  64'(finished_total));
        check_field("byte_sum",        64'(want.byte_sum),        64'(byte_sum));
        check_field("reused_total",    64'(want.reused_total),    64'(reused_total));
        check_field("untracked_total", 64'(want.untracked_total), 64'(untracked_total));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus.
  initial begin
    mon_event_t       ev;
    logic [31:0]      addr;
    logic [SizeW-1:0] goal;
    int               sent;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    cmd            = CMD_REQUEST;
    buffer_addr    = '0;
    buffer_length  = '0;
    received_bytes = '0;
    now_time       = '0;
    out_stall      = 1'b0;
    calm           = 1'b0;
    mismatches     = 0;
    idle_cycles    = 0;
    frame_goal     = '0;
    requests_seen  = '0;
    short_requests = '0;
    frames_done    = '0;
    bytes_received = '0;
    reuses         = '0;
    untracked      = '0;
    destination    = '0;
    for (int i = 0; i < TableEntries; i++) begin
      slot_addr[i]  = '0;
      slot_frame[i] = '0;
      slot_stamp[i] = '0;
      slot_size[i]  = '0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    write_frame_goal(24'd1000);
    foreach (directed_rows[r])
      send_event(directed_rows[r].ev, directed_rows[r].pinned, directed_rows[r].want);

    // Random phases, each with its own frame goal and address pool.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       goal = '0;
        1:       goal = '1;
        2:       goal = 24'd1;
        3:       goal = 24'd4096;
        default: goal = SizeW'($urandom);
      endcase
      write_frame_goal(goal);
      calm = (p == 2);
      for (int i = 0; i < PoolSize; i++) begin
        addr_pool[i] = $urandom;
        if (addr_pool[i] == '0) addr_pool[i] = 32'h1;
      end
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if ($urandom_range(99) < 60) begin
          // A full buffer cycle: request, finish, then lookup of the same buffer.
          addr = pick_address();
          send_event(make_event(CMD_REQUEST, addr), 1'b0, '0);
          send_event(make_event(CMD_FINISH, addr), 1'b0, '0);
          send_event(make_event(CMD_LOOKUP, addr), 1'b0, '0);
          sent += 3;
        end else begin
          if ($urandom_range(99) < 5) ev = make_event(CMD_RELEASE, pick_address());
          else ev = make_event(cmd_t'($urandom_range(2)), pick_address());
          send_event(ev, 1'b0, '0);
          sent++;
        end
      end
    end
    calm = 1'b0;

    // Drain, then allow for any late result.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TableEntries + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
